FILE: hdl/ciow_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ciow_pkg;

   // Field widths fixed by the item formats.
   localparam int QPOS_W   = 16;
   localparam int KIND_W   = 3;
   localparam int LEN_W    = 16;
   localparam int WIN_W    = 8;
   localparam int FIELD_W  = 20;
   localparam int OFS_W    = 21;
   localparam int OFS_MAX  = 1048575;

   // Register interface constants.
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd15;

   // Register index of the window width.
   localparam logic REG_INDEL_WINDOW = 1'b0;

   // Alignment operation codes; every other code is passed over.
   localparam logic [KIND_W-1:0] OP_MATCH     = 3'd0;
   localparam logic [KIND_W-1:0] OP_INSERTION = 3'd1;
   localparam logic [KIND_W-1:0] OP_DELETION  = 3'd2;

   // One alignment operation.
   typedef struct packed {
      logic [QPOS_W-1:0] query_pos;
      logic [KIND_W-1:0] op_kind;
      logic [LEN_W-1:0]  op_length;
      logic              last_op;
   } item_type;

   // One per-read result.
   typedef struct packed {
      logic signed [OFS_W-1:0] base_offset;
      logic                    in_deletion;
      logic [FIELD_W-1:0]      ins_low;
      logic [FIELD_W-1:0]      ins_high;
      logic [FIELD_W-1:0]      del_low;
      logic [FIELD_W-1:0]      del_high;
      logic                    insertion_near;
      logic                    deletion_near;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/ciow_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ciow_req_if;
   import ciow_pkg::*;

   logic              valid;
   logic              ready;
   logic [QPOS_W-1:0] query_pos;
   logic [KIND_W-1:0] op_kind;
   logic [LEN_W-1:0]  op_length;
   logic              last_op;

   modport source (output valid, query_pos, op_kind, op_length, last_op, input ready);
   modport sink   (input valid, query_pos, op_kind, op_length, last_op, output ready);
endinterface

`default_nettype wire

FILE: hdl/ciow_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ciow_rsp_if;
   import ciow_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OFS_W-1:0] base_offset;
   logic                    in_deletion;
   logic [FIELD_W-1:0]      ins_low;
   logic [FIELD_W-1:0]      ins_high;
   logic [FIELD_W-1:0]      del_low;
   logic [FIELD_W-1:0]      del_high;
   logic                    insertion_near;
   logic                    deletion_near;

   modport source (output valid, base_offset, in_deletion, ins_low, ins_high, del_low,
                   del_high, insertion_near, deletion_near, input ready);
   modport sink   (input valid, base_offset, in_deletion, ins_low, ins_high, del_low,
                   del_high, insertion_near, deletion_near, output ready);
endinterface

`default_nettype wire

FILE: hdl/ciow_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module ciow_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ciow_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [ciow_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [ciow_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output logic      [ciow_pkg::WIN_W-1:0]        indel_window
);
   import ciow_pkg::*;

   logic [WIN_W-1:0] window_ff;
   logic [WIN_W-1:0] window_in;
   logic             reg_index;
   logic             write_hit;

   // The register index is the word address; the byte lanes are ignored.
   assign reg_index = csr_paddr[2];
   assign write_hit = csr_psel && csr_penable && csr_pwrite && (reg_index == REG_INDEL_WINDOW);

   // Window width register, written at the access phase of a write transfer.
   always_comb begin
      window_in = window_ff;
      if (write_hit) begin
         window_in = csr_pwdata[WIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   // Read-back; addresses past the register list read as zero.
   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_INDEL_WINDOW) begin
         csr_prdata = {{(CSR_DATA_W-WIN_W){1'b0}}, window_ff};
      end
   end

   assign csr_pready   = 1'b1;
   assign indel_window = window_ff;
endmodule

`default_nettype wire

FILE: hdl/ciow_walk.sv
`timescale 1ns / 1ps
`default_nettype none

module ciow_walk #(
   parameter int ACC_WIDTH = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire ciow_pkg::item_type           item,
   input  wire logic [ciow_pkg::WIN_W-1:0]   indel_window,
   output ciow_pkg::result_type              result
);
   import ciow_pkg::*;

   // Signed working width: holds the sum of two totals and the window bounds.
   localparam int SW = ACC_WIDTH + 3;
   // Width for the offset before it is saturated to the result range.
   localparam int DW = ACC_WIDTH + 22;
   localparam logic signed [SW-1:0] ACC_MAX_S = SW'({ACC_WIDTH{1'b1}});
   localparam logic signed [DW-1:0] OFS_HI = DW'(OFS_MAX);
   localparam logic signed [DW-1:0] OFS_LO = -DW'(OFS_MAX);

   // Running state of the current read.
   logic [ACC_WIDTH-1:0] match_ff, delete_ff, insert_ff;
   logic [ACC_WIDTH-1:0] ins_low_ff, ins_high_ff, ins_mid_ff;
   logic [ACC_WIDTH-1:0] del_low_ff, del_high_ff, del_mid_ff;
   logic                 past_low_ff, past_query_ff, stopped_ff, hit_del_ff;

   logic [ACC_WIDTH-1:0] match_in, delete_in, insert_in;
   logic [ACC_WIDTH-1:0] ins_low_in, ins_high_in, ins_mid_in;
   logic [ACC_WIDTH-1:0] del_low_in, del_high_in, del_mid_in;
   logic                 past_low_in, past_query_in, stopped_in, hit_del_in;

   // State after this operation, before the end-of-read clear.
   logic [ACC_WIDTH-1:0] upd_match, upd_delete, upd_insert;
   logic [ACC_WIDTH-1:0] upd_ins_low, upd_ins_high, upd_ins_mid;
   logic [ACC_WIDTH-1:0] upd_del_low, upd_del_high, upd_del_mid;
   logic                 upd_past_low, upd_past_query, upd_stopped, upd_hit_del;

   logic [WIN_W:0]       half_up, half_dn;
   logic signed [SW-1:0] mid_s, low_s, high_s;
   logic [ACC_WIDTH-1:0] sum_match, sum_delete, sum_insert;
   logic signed [SW-1:0] pos_match, pos_delete, pos_insert;
   logic signed [DW-1:0] offset_full;

   function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] a,
                                                    input logic [LEN_W-1:0] b);
      logic [ACC_WIDTH:0] s;
      s = {1'b0, a} + {{(ACC_WIDTH+1-LEN_W){1'b0}}, b};
      return s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
   endfunction

   function automatic logic signed [SW-1:0] ext(input logic [ACC_WIDTH-1:0] v);
      return signed'({3'b000, v});
   endfunction

   function automatic logic [ACC_WIDTH-1:0] clamp_acc(input logic signed [SW-1:0] v);
      logic [ACC_WIDTH-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > ACC_MAX_S) begin
         r = {ACC_WIDTH{1'b1}};
      end else begin
         r = v[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic [FIELD_W-1:0] fit_field(input logic [ACC_WIDTH-1:0] v);
      logic [ACC_WIDTH+FIELD_W-1:0] wide;
      wide = {{FIELD_W{1'b0}}, v};
      return wide[FIELD_W-1:0];
   endfunction

   // Window bounds around the query position.
   always_comb begin
      half_up = ({1'b0, indel_window} + 9'd1) >> 1;
      half_dn = (indel_window == '0) ? '0 : ({1'b0, indel_window} - 9'd1) >> 1;
      mid_s   = signed'({{(SW-QPOS_W){1'b0}}, item.query_pos});
      low_s   = mid_s - signed'({{(SW-WIN_W-1){1'b0}}, half_up});
      high_s  = mid_s + signed'({{(SW-WIN_W-1){1'b0}}, half_dn});
   end

   // Saturated totals and the reference position each operation would reach.
   always_comb begin
      sum_match  = sat_add(match_ff, item.op_length);
      sum_delete = sat_add(delete_ff, item.op_length);
      sum_insert = sat_add(insert_ff, item.op_length);
      pos_match  = ext(sum_match) + ext(delete_ff);
      pos_delete = ext(match_ff) + ext(sum_delete);
      pos_insert = ext(match_ff) + ext(delete_ff);
   end

   // Apply one operation unless the walk has already stopped.
   always_comb begin
      upd_match      = match_ff;
      upd_delete     = delete_ff;
      upd_insert     = insert_ff;
      upd_ins_low    = ins_low_ff;
      upd_ins_high   = ins_high_ff;
      upd_ins_mid    = ins_mid_ff;
      upd_del_low    = del_low_ff;
      upd_del_high   = del_high_ff;
      upd_del_mid    = del_mid_ff;
      upd_past_low   = past_low_ff;
      upd_past_query = past_query_ff;
      upd_stopped    = stopped_ff;
      upd_hit_del    = hit_del_ff;
      if (!stopped_ff) begin
         unique case (item.op_kind)
            OP_MATCH: begin
               upd_match = sum_match;
               if (pos_match >= low_s) begin
                  upd_past_low = 1'b1;
                  if (pos_match >= mid_s) begin
                     upd_past_query = 1'b1;
                     if (pos_match >= high_s) begin
                        upd_stopped = 1'b1;
                     end
                  end
               end
            end
            OP_DELETION: begin
               upd_delete = sum_delete;
               if (pos_delete >= mid_s && !past_query_ff) begin
                  // The query position falls inside this deletion.
                  upd_hit_del = 1'b1;
                  upd_stopped = 1'b1;
               end else begin
                  if (pos_delete <= low_s) begin
                     upd_del_low = sum_delete;
                  end
                  upd_del_high = sum_delete;
                  if (pos_delete > low_s && !past_low_ff) begin
                     upd_del_low = clamp_acc(ext(sum_delete) - (pos_delete - low_s));
                  end
                  if (pos_delete <= mid_s) begin
                     upd_del_mid = sum_delete;
                  end
                  if (pos_delete >= high_s) begin
                     upd_del_high = clamp_acc(ext(sum_delete) - (pos_delete - high_s));
                     upd_stopped  = 1'b1;
                  end
               end
            end
            OP_INSERTION: begin
               upd_insert = sum_insert;
               if (pos_insert < low_s) begin
                  upd_ins_low = sum_insert;
               end
               if (pos_insert < mid_s) begin
                  upd_ins_mid = sum_insert;
               end
               upd_ins_high = sum_insert;
            end
            default: begin
               // Clips and unknown codes leave the walk untouched.
            end
         endcase
      end
   end

   // Next state: the updated walk, cleared again at the end of a read.
   always_comb begin
      match_in      = match_ff;
      delete_in     = delete_ff;
      insert_in     = insert_ff;
      ins_low_in    = ins_low_ff;
      ins_high_in   = ins_high_ff;
      ins_mid_in    = ins_mid_ff;
      del_low_in    = del_low_ff;
      del_high_in   = del_high_ff;
      del_mid_in    = del_mid_ff;
      past_low_in   = past_low_ff;
      past_query_in = past_query_ff;
      stopped_in    = stopped_ff;
      hit_del_in    = hit_del_ff;
      if (step) begin
         if (item.last_op) begin
            match_in      = '0;
            delete_in     = '0;
            insert_in     = '0;
            ins_low_in    = '0;
            ins_high_in   = '0;
            ins_mid_in    = '0;
            del_low_in    = '0;
            del_high_in   = '0;
            del_mid_in    = '0;
            past_low_in   = 1'b0;
            past_query_in = 1'b0;
            stopped_in    = 1'b0;
            hit_del_in    = 1'b0;
         end else begin
            match_in      = upd_match;
            delete_in     = upd_delete;
            insert_in     = upd_insert;
            ins_low_in    = upd_ins_low;
            ins_high_in   = upd_ins_high;
            ins_mid_in    = upd_ins_mid;
            del_low_in    = upd_del_low;
            del_high_in   = upd_del_high;
            del_mid_in    = upd_del_mid;
            past_low_in   = upd_past_low;
            past_query_in = upd_past_query;
            stopped_in    = upd_stopped;
            hit_del_in    = upd_hit_del;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff      <= '0;
         delete_ff     <= '0;
         insert_ff     <= '0;
         ins_low_ff    <= '0;
         ins_high_ff   <= '0;
         ins_mid_ff    <= '0;
         del_low_ff    <= '0;
         del_high_ff   <= '0;
         del_mid_ff    <= '0;
         past_low_ff   <= 1'b0;
         past_query_ff <= 1'b0;
         stopped_ff    <= 1'b0;
         hit_del_ff    <= 1'b0;
      end else begin
         match_ff      <= match_in;
         delete_ff     <= delete_in;
         insert_ff     <= insert_in;
         ins_low_ff    <= ins_low_in;
         ins_high_ff   <= ins_high_in;
         ins_mid_ff    <= ins_mid_in;
         del_low_ff    <= del_low_in;
         del_high_ff   <= del_high_in;
         del_mid_ff    <= del_mid_in;
         past_low_ff   <= past_low_in;
         past_query_ff <= past_query_in;
         stopped_ff    <= stopped_in;
         hit_del_ff    <= hit_del_in;
      end
   end

   // Read result from the updated walk; a hit deletion zeroes everything else.
   always_comb begin
      offset_full = signed'({{(DW-ACC_WIDTH){1'b0}}, upd_del_mid})
                  - signed'({{(DW-ACC_WIDTH){1'b0}}, upd_ins_mid});
      if (offset_full > OFS_HI) begin
         offset_full = OFS_HI;
      end else if (offset_full < OFS_LO) begin
         offset_full = OFS_LO;
      end
      result = '0;
      if (upd_hit_del) begin
         result.in_deletion = 1'b1;
      end else begin
         result.base_offset    = offset_full[OFS_W-1:0];
         result.ins_low        = fit_field(upd_ins_low);
         result.ins_high       = fit_field(upd_ins_high);
         result.del_low        = fit_field(upd_del_low);
         result.del_high       = fit_field(upd_del_high);
         result.insertion_near = upd_ins_high > upd_ins_low;
         result.deletion_near  = upd_del_high > upd_del_low;
      end
   end
endmodule

`default_nettype wire

FILE: hdl/ciow_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ciow_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire ciow_pkg::result_type result,
   output logic                      free,
   ciow_rsp_if.source                rsp_chan
);
   import ciow_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;
   result_type data_in;

   // The register can take a new result when empty or being emptied now.
   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.base_offset    = data_ff.base_offset;
   assign rsp_chan.in_deletion    = data_ff.in_deletion;
   assign rsp_chan.ins_low        = data_ff.ins_low;
   assign rsp_chan.ins_high       = data_ff.ins_high;
   assign rsp_chan.del_low        = data_ff.del_low;
   assign rsp_chan.del_high       = data_ff.del_high;
   assign rsp_chan.insertion_near = data_ff.insertion_near;
   assign rsp_chan.deletion_near  = data_ff.deletion_near;
endmodule

`default_nettype wire

FILE: hdl/cigar_indel_offset_walker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Transfer
// req_chan   in         one alignment operation of a read
// rsp_chan   out        one result per read, after its last operation
// csr_*      in/out     APB access to the window width register
//
// An operation is registered on acceptance and applied to the running totals
// from the input register; on a read's last operation the result enters the
// output register as that operation steps. One operation is taken every cycle
// unless the input stage stalls. Reset is synchronous, empties both stage
// registers and clears the walk. The input stage stalls only when it holds a
// read's last operation and the output register is full and not taken.

module cigar_indel_offset_walker #(
   parameter int ACC_WIDTH = 20
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ciow_req_if.sink                               req_chan,
   ciow_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ciow_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [ciow_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [ciow_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import ciow_pkg::*;

   logic             in_valid_ff;
   logic             in_valid_in;
   item_type         in_item_ff;
   item_type         in_item_in;
   logic             out_free;
   logic             step;
   logic [WIN_W-1:0] indel_window;
   result_type       result;

   ciow_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .indel_window (indel_window)
   );

   // The held operation moves on unless it ends a read and the result has
   // nowhere to go.
   assign step           = in_valid_ff && (!in_item_ff.last_op || out_free);
   assign req_chan.ready = !in_valid_ff || step;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_chan.ready) begin
         in_valid_in          = req_chan.valid;
         in_item_in.query_pos = req_chan.query_pos;
         in_item_in.op_kind   = req_chan.op_kind;
         in_item_in.op_length = req_chan.op_length;
         in_item_in.last_op   = req_chan.last_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   ciow_walk #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (in_item_ff),
      .indel_window (indel_window),
      .result       (result)
   );

   ciow_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (step && in_item_ff.last_op),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   // A read's last operation always leaves a result in the output register.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (step && in_item_ff.last_op) |=> rsp_chan.valid)
      else $error("last operation did not produce a result");

   // A query inside a deletion reports a zero offset, zero high fields and no near flags.
   a_deletion_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.in_deletion) |->
         (rsp_chan.base_offset == '0 && rsp_chan.ins_high == '0 &&
          rsp_chan.del_high == '0 && !rsp_chan.insertion_near && !rsp_chan.deletion_near))
      else $error("deletion hit result carries non-zero fields");

   // The window width comes out of reset at its documented value.
   a_window_reset: assert property (@(posedge clock)
      $past(reset) |-> (indel_window == WINDOW_RESET))
      else $error("window width not at reset value");
endmodule

`default_nettype wire

FILE: tb/ciow_tb_pkg.sv
`timescale 1ns / 1ps

package ciow_tb_pkg;
   import ciow_pkg::*;

   // Accumulator width the block is built with in this bench.
   localparam int     ACC_W   = 20;
   localparam longint ACC_TOP = (longint'(1) << ACC_W) - 1;

   // Operation codes the block passes over.
   localparam logic [KIND_W-1:0] OP_SOFT_CLIP     = 3'd3;
   localparam logic [KIND_W-1:0] OP_HARD_CLIP     = 3'd4;
   localparam logic [KIND_W-1:0] OP_FIRST_INVALID = 3'd5;
   localparam logic [KIND_W-1:0] OP_LAST_CODE     = 3'd7;

   // Walks each read alongside the block and holds the results still owed.
   class walk_scoreboard;
      logic [WIN_W-1:0] window;
      bit [ACC_W-1:0]   match_sum, del_sum, ins_sum;
      bit               beyond_low, beyond_query, halted, landed_in_del;
      bit [ACC_W-1:0]   ins_at_low, ins_at_high, ins_at_query;
      bit [ACC_W-1:0]   del_at_low, del_at_high, del_at_query;
      result_type       owed_results[$];
      int               errors;
      int               ops_taken;
      int               results_checked;
      int               deletion_reads;
      int               saturated_reads;

      function new();
         window          = WINDOW_RESET;
         errors          = 0;
         ops_taken       = 0;
         results_checked = 0;
         deletion_reads  = 0;
         saturated_reads = 0;
         clear_walk();
      endfunction

      function void clear_walk();
         match_sum     = '0;
         del_sum       = '0;
         ins_sum       = '0;
         beyond_low    = 1'b0;
         beyond_query  = 1'b0;
         halted        = 1'b0;
         landed_in_del = 1'b0;
         ins_at_low    = '0;
         ins_at_high   = '0;
         ins_at_query  = '0;
         del_at_low    = '0;
         del_at_high   = '0;
         del_at_query  = '0;
      endfunction

      function bit [ACC_W-1:0] sat_sum(bit [ACC_W-1:0] total, logic [LEN_W-1:0] len);
         longint s;
         s = longint'(total) + longint'(len);
         return (s > ACC_TOP) ? ACC_TOP[ACC_W-1:0] : s[ACC_W-1:0];
      endfunction

      function bit [ACC_W-1:0] clamp_total(longint v);
         if (v < 0) return '0;
         if (v > ACC_TOP) return ACC_TOP[ACC_W-1:0];
         return v[ACC_W-1:0];
      endfunction

      // Moves the running totals on by one operation and records the window bounds.
      function void advance(item_type op);
         longint w, mid, lo, hi, pos;
         w   = longint'(window);
         mid = longint'(op.query_pos);
         lo  = mid - (w + 1) / 2;
         hi  = mid + (w - 1) / 2;
         case (op.op_kind)
            OP_MATCH: begin
               match_sum = sat_sum(match_sum, op.op_length);
               pos = longint'(match_sum) + longint'(del_sum);
               if (pos >= lo) begin
                  beyond_low = 1'b1;
                  if (pos >= mid) begin
                     beyond_query = 1'b1;
                     if (pos >= hi) halted = 1'b1;
                  end
               end
            end
            OP_DELETION: begin
               del_sum = sat_sum(del_sum, op.op_length);
               pos = longint'(match_sum) + longint'(del_sum);
               if (pos >= mid && !beyond_query) begin
                  // The query falls inside this deletion: the walk ends here.
                  landed_in_del = 1'b1;
                  halted        = 1'b1;
               end else begin
                  if (pos <= lo) del_at_low = del_sum;
                  del_at_high = del_sum;
                  if (pos > lo && !beyond_low)
                     del_at_low = clamp_total(longint'(del_sum) - (pos - lo));
                  if (pos <= mid) del_at_query = del_sum;
                  if (pos >= hi) begin
                     del_at_high = clamp_total(longint'(del_sum) - (pos - hi));
                     halted      = 1'b1;
                  end
               end
            end
            OP_INSERTION: begin
               ins_sum = sat_sum(ins_sum, op.op_length);
               pos = longint'(match_sum) + longint'(del_sum);
               if (pos < lo) ins_at_low = ins_sum;
               if (pos < mid) ins_at_query = ins_sum;
               ins_at_high = ins_sum;
            end
            default: ;
         endcase
      endfunction

      // Called for every accepted operation; the last one of a read owes a result.
      function void note_op(item_type op);
         result_type r;
         longint     d;
         ops_taken++;
         if (!halted) advance(op);
         if (op.last_op) begin
            r = '0;
            if (landed_in_del) begin
               r.in_deletion = 1'b1;
               deletion_reads++;
            end else begin
               d = longint'(del_at_query) - longint'(ins_at_query);
               if (d > OFS_MAX) d = OFS_MAX;
               if (d < -OFS_MAX) d = -OFS_MAX;
               r.base_offset    = d[OFS_W-1:0];
               r.ins_low        = ins_at_low[FIELD_W-1:0];
               r.ins_high       = ins_at_high[FIELD_W-1:0];
               r.del_low        = del_at_low[FIELD_W-1:0];
               r.del_high       = del_at_high[FIELD_W-1:0];
               r.insertion_near = (ins_at_high > ins_at_low);
               r.deletion_near  = (del_at_high > del_at_low);
               if (ins_sum == ACC_TOP[ACC_W-1:0]) saturated_reads++;
            end
            owed_results = {owed_results, r};
            clear_walk();
         end
      endfunction

      // Prints one line per mismatch and counts it.
      task report(string what);
         $display("[%0t] MISMATCH: %s", $time, what);
         errors++;
      endtask

      task check_result(result_type got);
         result_type exp;
         if (owed_results.size() == 0) begin
            report("result transfer with no result outstanding");
            return;
         end
         exp = owed_results.pop_front();
         if (got.base_offset !== exp.base_offset)
            report($sformatf("result %0d base_offset %0d, expected %0d",
                             results_checked, got.base_offset, exp.base_offset));
         if (got.in_deletion !== exp.in_deletion)
            report($sformatf("result %0d in_deletion %b, expected %b",
                             results_checked, got.in_deletion, exp.in_deletion));
         if (got.ins_low !== exp.ins_low)
            report($sformatf("result %0d ins_low %0d, expected %0d",
                             results_checked, got.ins_low, exp.ins_low));
         if (got.ins_high !== exp.ins_high)
            report($sformatf("result %0d ins_high %0d, expected %0d",
                             results_checked, got.ins_high, exp.ins_high));
         if (got.del_low !== exp.del_low)
            report($sformatf("result %0d del_low %0d, expected %0d",
                             results_checked, got.del_low, exp.del_low));
         if (got.del_high !== exp.del_high)
            report($sformatf("result %0d del_high %0d, expected %0d",
                             results_checked, got.del_high, exp.del_high));
         if (got.insertion_near !== exp.insertion_near)
            report($sformatf("result %0d insertion_near %b, expected %b",
                             results_checked, got.insertion_near, exp.insertion_near));
         if (got.deletion_near !== exp.deletion_near)
            report($sformatf("result %0d deletion_near %b, expected %b",
                             results_checked, got.deletion_near, exp.deletion_near));
         results_checked++;
      endtask

      task flag_leftovers();
         if (owed_results.size() != 0)
            report($sformatf("%0d results never arrived", owed_results.size()));
      endtask
   endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import ciow_pkg::*;
   import ciow_tb_pkg::*;

   localparam int IDLE_LIMIT    = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_OPS     = 115;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = CSR_ADDR_W'(REG_INDEL_WINDOW) << 2;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ciow_req_if req_bus ();
   ciow_rsp_if rsp_bus ();

   cigar_indel_offset_walker #(
      .ACC_WIDTH   (ACC_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   walk_scoreboard sb;
   int             burst_left;
   int             useful_ops;
   int             settings_used;
   int             idle_cycles;
   int             hold_requests;

   // Free-running clock, 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Every transfer on either channel goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_op('{query_pos: req_bus.query_pos, op_kind: req_bus.op_kind,
                         op_length: req_bus.op_length, last_op: req_bus.last_op});
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result('{base_offset: rsp_bus.base_offset,
                              in_deletion: rsp_bus.in_deletion,
                              ins_low: rsp_bus.ins_low, ins_high: rsp_bus.ins_high,
                              del_low: rsp_bus.del_low, del_high: rsp_bus.del_high,
                              insertion_near: rsp_bus.insertion_near,
                              deletion_near: rsp_bus.deletion_near});
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Result receiver: runs of ready and stall, plus one long hold-off on request.
   initial begin
      int run_left;
      int hold_left;
      int holds_done;
      bit level;
      rsp_bus.ready = 1'b0;
      run_left      = 0;
      hold_left     = 0;
      holds_done    = 0;
      level         = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            hold_left  = HOLD_CYCLES;
            holds_done = hold_requests;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               case ($urandom_range(0, 3))
                  0: begin
                     level    = 1'b1;
                     run_left = $urandom_range(20, 60);
                  end
                  1: begin
                     level    = 1'b0;
                     run_left = $urandom_range(1, 6);
                  end
                  default: begin
                     level    = $urandom_range(0, 1);
                     run_left = $urandom_range(1, 4);
                  end
               endcase
            end
            run_left--;
            rsp_bus.ready <= level;
         end
      end
   end

   // Offers one operation and waits for its transfer; bursts end in random gaps, some empty.
   task send_op(input logic [QPOS_W-1:0] q, input logic [KIND_W-1:0] kind,
                input logic [LEN_W-1:0] len, input logic last);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_bus.valid     <= 1'b1;
      req_bus.query_pos <= q;
      req_bus.op_kind   <= kind;
      req_bus.op_length <= len;
      req_bus.last_op   <= last;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      if (kind <= OP_DELETION) useful_ops++;
   endtask

   // Stops offering, waits for every owed result, then lets the pipeline empty.
   task settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task check_window();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= WINDOW_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(sb.window))
         sb.report($sformatf("window register reads %0d, expected %0d",
                             csr_prdata, sb.window));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task write_window(input logic [WIN_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WINDOW_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.window = value;
      settings_used++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      check_window();
   endtask

   function automatic logic [KIND_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return OP_MATCH;
      if (r < 60) return OP_INSERTION;
      if (r < 80) return OP_DELETION;
      if (r < 87) return OP_SOFT_CLIP;
      if (r < 93) return OP_HARD_CLIP;
      return KIND_W'($urandom_range(OP_FIRST_INVALID, OP_LAST_CODE));
   endfunction

   // One random read: mostly well-formed walks, some wide-valued, some
   // insertion floods that can saturate, and some noise with stray read ends.
   task send_read();
      int               style;
      int               nops;
      int               i;
      bit               wide;
      logic [QPOS_W-1:0] q;
      style = $urandom_range(0, 99);
      if (style < 5) begin
         q    = QPOS_W'($urandom);
         nops = $urandom_range(17, 20);
         for (i = 0; i < nops; i++)
            send_op(q, OP_INSERTION, LEN_W'($urandom_range(60000, 65535)), i == nops - 1);
      end else if (style < 85) begin
         wide = (style >= 75);
         q    = wide ? QPOS_W'($urandom) : QPOS_W'($urandom_range(0, 200));
         nops = $urandom_range(1, 10);
         for (i = 0; i < nops; i++)
            send_op(q, pick_kind(),
                    wide ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 40)),
                    i == nops - 1);
      end else begin
         nops = $urandom_range(1, 6);
         for (i = 0; i < nops; i++)
            send_op(QPOS_W'($urandom), KIND_W'($urandom), LEN_W'($urandom),
                    (i == nops - 1) || ($urandom_range(0, 4) == 0));
      end
   endtask

   // Main sequence: reset, directed reads, then random phases per window width.
   initial begin
      logic [WIN_W-1:0] widths [6];
      int               p;
      sb                = new();
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.query_pos = '0;
      req_bus.op_kind   = OP_MATCH;
      req_bus.op_length = '0;
      req_bus.last_op   = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      burst_left        = 0;
      useful_ops        = 0;
      settings_used     = 1;
      hold_requests     = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The window starts at its reset width.
      check_window();

      // A read crossing every bound, with clips mixed in.
      send_op(16'd20, OP_SOFT_CLIP, 16'd5, 1'b0);
      send_op(16'd20, OP_MATCH, 16'd10, 1'b0);
      send_op(16'd20, OP_INSERTION, 16'd3, 1'b0);
      send_op(16'd20, OP_DELETION, 16'd4, 1'b0);
      send_op(16'd20, OP_MATCH, 16'd10, 1'b0);
      send_op(16'd20, OP_INSERTION, 16'd2, 1'b0);
      send_op(16'd20, OP_HARD_CLIP, 16'd7, 1'b0);
      send_op(16'd20, OP_MATCH, 16'd10, 1'b1);
      // Query inside a deletion; later operations are absorbed.
      send_op(16'd10, OP_MATCH, 16'd5, 1'b0);
      send_op(16'd10, OP_DELETION, 16'd10, 1'b0);
      send_op(16'd10, OP_MATCH, 16'd3, 1'b0);
      send_op(16'd10, OP_FIRST_INVALID, 16'd1, 1'b1);
      // Extreme single-operation reads.
      send_op(16'hFFFF, OP_LAST_CODE, 16'hFFFF, 1'b1);
      send_op(16'd0, OP_MATCH, 16'd0, 1'b1);
      send_op(16'd0, OP_DELETION, 16'hFFFF, 1'b1);
      // Walk stopped at the high bound, then absorbed operations.
      send_op(16'd5, OP_MATCH, 16'd12, 1'b0);
      send_op(16'd5, OP_INSERTION, 16'd100, 1'b0);
      send_op(16'd5, OP_DELETION, 16'd100, 1'b1);
      // Large insertion before the query gives a negative offset.
      send_op(16'hFFFF, OP_INSERTION, 16'hFFFF, 1'b0);
      send_op(16'hFFFF, OP_MATCH, 16'hFFFF, 1'b0);
      send_op(16'hFFFF, OP_FIRST_INVALID + 3'd1, 16'd0, 1'b1);
      // Deletion running past the high bound.
      send_op(16'd30, OP_MATCH, 16'd30, 1'b0);
      send_op(16'd30, OP_DELETION, 16'd20, 1'b1);
      settle();

      widths[0] = '0;
      widths[1] = '1;
      widths[2] = 8'd1;
      widths[3] = WIN_W'($urandom);
      widths[4] = 8'd254;
      widths[5] = WIN_W'($urandom);
      for (p = 0; p < 6; p++) begin
         write_window(widths[p]);
         // One phase starts with a long receiver hold-off so the block backs up.
         if (p == 2) hold_requests++;
         useful_ops = 0;
         while (useful_ops < PHASE_OPS) send_read();
         settle();
      end

      sb.flag_leftovers();
      $display("Run covered %0d operations and %0d read results over %0d window widths.",
               sb.ops_taken, sb.results_checked, settings_used);
      $display("%0d reads ended with the query in a deletion, %0d saturated the insertions.",
               sb.deletion_reads, sb.saturated_reads);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
